FILE: src/cmds_pkg.sv
// ----------------------------------------------------------------------------
// cmds_pkg
// Shared widths, register indexes, reset values and beat types for the
// center-mean dark segmenter.
// ----------------------------------------------------------------------------
package cmds_pkg;

   localparam int CFG_W     = 12;
   localparam int PIX_W     = 8;
   localparam int SUM_W     = 24;
   localparam int CSR_IDX_W = 2;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_LIMIT     = 2'd2;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [PIX_W-1:0] UV_LIMIT_RST     = 8'd138;

   // opcodes
   localparam logic OP_MEASURE  = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // pixel classes
   localparam logic CLASS_DARK  = 1'b0;
   localparam logic CLASS_UNDEF = 1'b1;

   // classify pixel traveling beside the mean computation
   typedef struct packed {
      logic             latch;
      logic [PIX_W-1:0] gray;
      logic [PIX_W-1:0] chroma;
   } cls_item_type;

   // one result beat
   typedef struct packed {
      logic             pixel_class;
      logic [PIX_W-1:0] mean_level;
   } rsp_beat_type;

endpackage

FILE: src/cmds_window_acc.sv
// ----------------------------------------------------------------------------
// cmds_window_acc
// Raster position counters and saturating window sum for measure pixels.
// ----------------------------------------------------------------------------
module cmds_window_acc
   import cmds_pkg::*;
#(
   parameter int HALF_WINDOW = 25,
   parameter int MAX_DIM     = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] frame_width,
   input  logic [CFG_W-1:0] frame_height,
   input  logic             in_valid,
   input  logic             in_opcode,
   input  logic             in_first,
   input  logic [PIX_W-1:0] in_gray,
   output logic [SUM_W-1:0] window_sum,
   output logic             latch_mean
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int BND_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;
   localparam logic [BND_W-1:0] HW_B  = BND_W'(HALF_WINDOW);
   localparam logic [BND_W-1:0] DIM_B = BND_W'(MAX_DIM);

   logic [BND_W-1:0] col_lo_ff, col_hi_ff, row_lo_ff, row_hi_ff;
   logic [BND_W-1:0] col_lo_in, col_hi_in, row_lo_in, row_hi_in;
   logic [BND_W-1:0] col_mid, row_mid;

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             last_meas_ff, last_meas_in;

   logic             meas;
   logic [POS_W-1:0] col_eff, row_eff;
   logic [BND_W-1:0] col_b, row_b, col_nxt, row_nxt;
   logic             in_win, wrap;
   logic [SUM_W-1:0] sum_base;
   logic [SUM_W:0]   sum_add;

   // window bounds follow the frame size
   always_comb begin
      col_mid   = BND_W'(frame_width >> 1);
      row_mid   = BND_W'(frame_height >> 1);
      col_lo_in = (col_mid >= HW_B) ? col_mid - HW_B : '0;
      row_lo_in = (row_mid >= HW_B) ? row_mid - HW_B : '0;
      col_hi_in = col_mid + HW_B;
      row_hi_in = row_mid + HW_B;
   end

   always_comb begin
      meas     = in_valid && (in_opcode == OP_MEASURE);
      col_eff  = in_first ? '0 : col_ff;
      row_eff  = in_first ? '0 : row_ff;
      col_b    = BND_W'(col_eff);
      row_b    = BND_W'(row_eff);
      in_win   = (row_b >= row_lo_ff) && (row_b < row_hi_ff) &&
                 (col_b >= col_lo_ff) && (col_b < col_hi_ff);
      sum_base = in_first ? '0 : sum_ff;
      sum_add  = {1'b0, sum_base} + (SUM_W+1)'(in_win ? in_gray : '0);
      col_nxt  = col_b + BND_W'(1);
      row_nxt  = row_b + BND_W'(1);
      wrap     = (col_nxt >= BND_W'(frame_width)) || (col_nxt >= DIM_B);

      sum_in       = sum_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      last_meas_in = last_meas_ff;
      if (meas) begin
         sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         if (wrap) begin
            col_in = '0;
            row_in = (row_nxt < DIM_B) ? row_nxt[POS_W-1:0] : row_eff;
         end else begin
            col_in = col_nxt[POS_W-1:0];
            row_in = row_eff;
         end
      end
      if (in_valid) begin
         last_meas_in = meas;
      end
   end

   always_ff @(posedge clock) begin
      col_lo_ff <= col_lo_in;
      col_hi_ff <= col_hi_in;
      row_lo_ff <= row_lo_in;
      row_hi_ff <= row_hi_in;
      if (reset) begin
         sum_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         last_meas_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         last_meas_ff <= last_meas_in;
      end
   end

   assign window_sum = sum_ff;
   assign latch_mean = in_first || last_meas_ff;

endmodule

FILE: src/cmds_mean_div.sv
// ----------------------------------------------------------------------------
// cmds_mean_div
// Four-stage rounded mean: reciprocal multiply, remainder correction,
// round half to even and saturate.
// ----------------------------------------------------------------------------
module cmds_mean_div
   import cmds_pkg::*;
#(
   parameter int HALF_WINDOW = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [SUM_W-1:0] in_sum,
   input  cls_item_type     in_item,
   output logic             out_valid,
   output logic [PIX_W-1:0] out_mean,
   output cls_item_type     out_item
);

   localparam int DIV_D_I = 4 * HALF_WINDOW * HALF_WINDOW;
   localparam int DIV_W   = $clog2(256 * DIV_D_I);
   localparam int Q_W     = PIX_W + 1;
   localparam int RECIP_I = (1 << DIV_W) / DIV_D_I;
   localparam logic [DIV_W-1:0] DIV_D   = DIV_W'(DIV_D_I);
   localparam logic [DIV_W-1:0] RECIP   = DIV_W'(RECIP_I);
   localparam logic [SUM_W-1:0] SAT_SUM = SUM_W'(256 * DIV_D_I);

   // stage A: sum snapshot
   logic             a_valid_ff;
   logic [SUM_W-1:0] a_sum_ff;
   cls_item_type     a_item_ff;

   // stage B: quotient estimate
   logic             b_valid_ff, b_big_ff, b_big_in;
   logic [DIV_W-1:0] b_s_ff, b_s_in;
   logic [Q_W-1:0]   b_q_ff, b_q_in;
   cls_item_type     b_item_ff;
   logic [2*DIV_W-1:0] prod;

   // stage C: corrected quotient and remainder
   logic             c_valid_ff, c_big_ff;
   logic [Q_W-1:0]   c_q_ff, c_q_in;
   logic [DIV_W-1:0] c_r_ff, c_r_in;
   cls_item_type     c_item_ff;
   logic [DIV_W-1:0] qd, rem;
   logic             corr;

   // stage D: rounded, saturated mean
   logic             d_valid_ff;
   logic [PIX_W-1:0] d_mean_ff, d_mean_in;
   cls_item_type     d_item_ff;
   logic [DIV_W:0]   r2, d2;
   logic             rnd;
   logic [Q_W-1:0]   q2;

   always_comb begin
      b_big_in = a_sum_ff >= SAT_SUM;
      b_s_in   = a_sum_ff[DIV_W-1:0];
      prod     = (2*DIV_W)'(b_s_in) * (2*DIV_W)'(RECIP);
      b_q_in   = prod[DIV_W+Q_W-1:DIV_W];
   end

   always_comb begin
      qd     = DIV_W'(b_q_ff) * DIV_D;
      rem    = b_s_ff - qd;
      corr   = rem >= DIV_D;
      c_q_in = b_q_ff + Q_W'(corr);
      c_r_in = corr ? rem - DIV_D : rem;
   end

   always_comb begin
      r2        = {c_r_ff, 1'b0};
      d2        = {1'b0, DIV_D};
      rnd       = (r2 > d2) || ((r2 == d2) && c_q_ff[0]);
      q2        = c_q_ff + Q_W'(rnd);
      d_mean_in = (c_big_ff || q2[PIX_W]) ? '1 : q2[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      a_sum_ff  <= in_sum;
      a_item_ff <= in_item;
      b_big_ff  <= b_big_in;
      b_s_ff    <= b_s_in;
      b_q_ff    <= b_q_in;
      b_item_ff <= a_item_ff;
      c_big_ff  <= b_big_ff;
      c_q_ff    <= c_q_in;
      c_r_ff    <= c_r_in;
      c_item_ff <= b_item_ff;
      d_mean_ff <= d_mean_in;
      d_item_ff <= c_item_ff;
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_mean  = d_mean_ff;
   assign out_item  = d_item_ff;

endmodule

FILE: src/cmds_rsp_fifo.sv
// ----------------------------------------------------------------------------
// cmds_rsp_fifo
// Small result queue that decouples the pipeline from rsp_stall.
// ----------------------------------------------------------------------------
module cmds_rsp_fifo
   import cmds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_beat_type push_beat,
   input  logic         pop,
   output logic         out_valid,
   output rsp_beat_type out_beat
);

   rsp_beat_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_CW-1:0] rd_ptr_ff, rd_ptr_in;

   always_comb begin
      out_valid = wr_ptr_ff != rd_ptr_ff;
      out_beat  = mem_ff[rd_ptr_ff[FIFO_AW-1:0]];
      wr_ptr_in = push ? wr_ptr_ff + FIFO_CW'(1) : wr_ptr_ff;
      rd_ptr_in = (pop && out_valid) ? rd_ptr_ff + FIFO_CW'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[FIFO_AW-1:0]] <= push_beat;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

FILE: src/center_mean_dark_segmenter_top.sv
// A classify beat passes the input register, four divider stages and the queue to rsp_valid.
// Throughput: one beat per cycle on both passes while req_stall is low.
// req_stall rises when eight classify beats are in flight (pipeline plus result queue).
// Reset is synchronous: it clears counters, window sum, threshold and the queue, and restores
// frame_width 640, frame_height 480 and uv_limit 138. No beat is taken while reset is high.
// ----------------------------------------------------------------------------
// center_mean_dark_segmenter_top
// Two-pass segmenter: the measure pass sums gray over a centered window,
// the classify pass marks pixels dark against the rounded window mean and the chroma limit.
// ----------------------------------------------------------------------------
module center_mean_dark_segmenter_top
   import cmds_pkg::*;
#(
   parameter int HALF_WINDOW = 25,
   parameter int MAX_DIM     = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration port
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   // input channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic                 req_first_of_pass,
   input  logic [PIX_W-1:0]     req_gray,
   input  logic [PIX_W-1:0]     req_chroma,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pixel_class,
   output logic [PIX_W-1:0]     rsp_mean_level
);

   // configuration registers
   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [PIX_W-1:0] uv_limit_ff, uv_limit_in;

   // input register stage
   logic             s0_valid_ff, s0_valid_in;
   logic             s0_op_ff, s0_first_ff;
   logic [PIX_W-1:0] s0_gray_ff, s0_chroma_ff;

   // in-flight classify beats, bounded by the result queue depth
   logic [FIFO_CW-1:0] inflight_ff, inflight_in;

   logic             req_take, rsp_take;
   logic [SUM_W-1:0] window_sum;
   logic             latch_mean;
   cls_item_type     cls_item;

   logic             m_valid;
   logic [PIX_W-1:0] m_mean;
   cls_item_type     m_item;

   logic [PIX_W-1:0] thr_ff, thr_in;
   logic [PIX_W-1:0] thr_use;
   rsp_beat_type     push_beat, out_beat;

   // hold the input while the queue could overflow or reset is active
   assign req_stall = reset || (inflight_ff == FIFO_CW'(FIFO_DEPTH));
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // configuration writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      uv_limit_in     = uv_limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            CSR_UV_LIMIT:     uv_limit_in     = csr_wdata[PIX_W-1:0];
            default:          ;
         endcase
      end
   end

   // count classify beats from acceptance until the result beat leaves
   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && (req_opcode == OP_CLASSIFY) && !rsp_take) begin
         inflight_in = inflight_ff + FIFO_CW'(1);
      end else if (rsp_take && !(req_take && (req_opcode == OP_CLASSIFY))) begin
         inflight_in = inflight_ff - FIFO_CW'(1);
      end
   end

   assign s0_valid_in = req_take;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_op_ff     <= req_opcode;
         s0_first_ff  <= req_first_of_pass;
         s0_gray_ff   <= req_gray;
         s0_chroma_ff <= req_chroma;
      end
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         uv_limit_ff     <= UV_LIMIT_RST;
         s0_valid_ff     <= 1'b0;
         inflight_ff     <= '0;
         thr_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         uv_limit_ff     <= uv_limit_in;
         s0_valid_ff     <= s0_valid_in;
         inflight_ff     <= inflight_in;
         thr_ff          <= thr_in;
      end
   end

   // measure pass: position tracking and window sum
   cmds_window_acc #(
      .HALF_WINDOW (HALF_WINDOW),
      .MAX_DIM     (MAX_DIM)
   ) u_acc (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .in_valid     (s0_valid_ff),
      .in_opcode    (s0_op_ff),
      .in_first     (s0_first_ff),
      .in_gray      (s0_gray_ff),
      .window_sum   (window_sum),
      .latch_mean   (latch_mean)
   );

   // a classify beat latches a fresh mean at pass start or right after measuring
   always_comb begin
      cls_item.latch  = latch_mean;
      cls_item.gray   = s0_gray_ff;
      cls_item.chroma = s0_chroma_ff;
   end

   cmds_mean_div #(
      .HALF_WINDOW (HALF_WINDOW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff && (s0_op_ff == OP_CLASSIFY)),
      .in_sum    (window_sum),
      .in_item   (cls_item),
      .out_valid (m_valid),
      .out_mean  (m_mean),
      .out_item  (m_item)
   );

   // classify against the latched threshold; beats arrive in order
   always_comb begin
      thr_use = m_item.latch ? m_mean : thr_ff;
      thr_in  = m_valid ? thr_use : thr_ff;
      push_beat.pixel_class = ((m_item.gray < thr_use) && (m_item.chroma < uv_limit_ff))
                              ? CLASS_DARK : CLASS_UNDEF;
      push_beat.mean_level  = thr_use;
   end

   cmds_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (m_valid),
      .push_beat (push_beat),
      .pop       (rsp_take),
      .out_valid (rsp_valid),
      .out_beat  (out_beat)
   );

   assign rsp_pixel_class = out_beat.pixel_class;
   assign rsp_mean_level  = out_beat.mean_level;

endmodule

FILE: tb/sv/center_mean_dark_segmenter_top_tb.sv
// ----------------------------------------------------------------------------
// center_mean_dark_segmenter_top_tb
// Self-checking bench for the two-pass dark segmenter. Measure and classify
// beats stream through a queue-fed driver. Every accepted beat also goes to
// an in-bench copy of the window sum, position counters and mean latch. A
// monitor compares each result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module center_mean_dark_segmenter_top_tb;
   import cmds_pkg::*;

   localparam int HALF_WIN   = 25;
   localparam int MAX_DIM    = 2048;
   localparam int WIN_AREA   = 4 * HALF_WIN * HALF_WIN;
   localparam int SUM_LIMIT  = (1 << SUM_W) - 1;
   localparam int RAND_ITEMS = 800;
   localparam int CALM_ITEMS = 650;    // idling stops past this many random items
   localparam int REPORT_CAP = 100;
   localparam int LIMIT_TIME = 20_000_000;

   // one input beat as the driver holds it
   typedef struct packed {
      logic             opcode;
      logic             first;
      logic [PIX_W-1:0] gray;
      logic [PIX_W-1:0] chroma;
   } pixel_beat_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_write         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index         = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0]     csr_wdata         = '0;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic                 req_opcode        = OP_MEASURE;
   logic                 req_first_of_pass = 1'b0;
   logic [PIX_W-1:0]     req_gray          = '0;
   logic [PIX_W-1:0]     req_chroma        = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic                 rsp_pixel_class;
   logic [PIX_W-1:0]     rsp_mean_level;

   center_mean_dark_segmenter_top #(
      .HALF_WINDOW (HALF_WIN),
      .MAX_DIM     (MAX_DIM)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_first_of_pass (req_first_of_pass),
      .req_gray          (req_gray),
      .req_chroma        (req_chroma),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_class   (rsp_pixel_class),
      .rsp_mean_level    (rsp_mean_level)
   );

   always #5 clock = ~clock;

   // Beats still to be driven, and results predicted but not yet seen.
   pixel_beat_type pixel_stream[$];
   rsp_beat_type   class_forecast[$];

   // Bench copy of the registers, tracked at the edge each write lands.
   logic [CFG_W-1:0] cfg_width  = FRAME_WIDTH_RST;
   logic [CFG_W-1:0] cfg_height = FRAME_HEIGHT_RST;
   logic [PIX_W-1:0] cfg_uv     = UV_LIMIT_RST;

   // Bench copy of the segmenter state, at its reset values.
   logic [SUM_W-1:0] win_sum       = '0;
   logic [10:0]      pos_row       = '0;
   logic [10:0]      pos_col       = '0;
   logic [PIX_W-1:0] held_mean     = '0;
   logic             after_measure = 1'b0;

   int error_count  = 0;
   int idle_odds    = 0;   // 0: no idling, else a burst starts one time in idle_odds
   int gap_left     = 0;
   int stall_left   = 0;
   int random_items = 0;

   // Fold one accepted beat into the state; a classify beat yields one result.
   task automatic segment_pixel(input pixel_beat_type px);
      int           h_mid, w_mid, row_lo, col_lo, total, quot, remn;
      rsp_beat_type outcome;
      if (px.opcode == OP_MEASURE) begin
         // a pass start clears the sum and puts this pixel at row 0, column 0
         if (px.first) begin
            win_sum = '0;
            pos_row = '0;
            pos_col = '0;
         end
         h_mid  = cfg_height >> 1;
         w_mid  = cfg_width >> 1;
         // clamp the window start to 0 on a small frame
         row_lo = (h_mid >= HALF_WIN) ? h_mid - HALF_WIN : 0;
         col_lo = (w_mid >= HALF_WIN) ? w_mid - HALF_WIN : 0;
         if (pos_row >= row_lo && pos_row < h_mid + HALF_WIN &&
             pos_col >= col_lo && pos_col < w_mid + HALF_WIN) begin
            total   = win_sum + px.gray;
            win_sum = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
         end
         // wrap the column at the frame width or the largest dimension,
         // then advance the row up to its ceiling
         if (pos_col + 1 >= cfg_width || pos_col + 1 >= MAX_DIM) begin
            pos_col = '0;
            if (pos_row + 1 < MAX_DIM)
               pos_row = pos_row + 1'b1;
         end else begin
            pos_col = pos_col + 1'b1;
         end
         after_measure = 1'b1;
      end else begin
         // latch the mean, rounded half to even, on a pass start or after measuring
         if (px.first || after_measure) begin
            quot = win_sum / WIN_AREA;
            remn = win_sum % WIN_AREA;
            if (2 * remn > WIN_AREA || (2 * remn == WIN_AREA && quot[0]))
               quot++;
            held_mean = (quot > 255) ? 8'd255 : quot[PIX_W-1:0];
         end
         after_measure       = 1'b0;
         outcome.pixel_class = (px.gray < held_mean && px.chroma < cfg_uv) ?
                               CLASS_DARK : CLASS_UNDEF;
         outcome.mean_level  = held_mean;
         class_forecast.push_back(outcome);
      end
   endtask

   task automatic flag_mismatch(input string field, input int want_v, input int got_v);
      error_count++;
      if (error_count <= REPORT_CAP)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
   endtask

   // Driver: advance to the next beat only once the current one is taken.
   // Random gaps drop valid between beats, never under a held beat.
   always @(posedge clock) begin : feed_req
      pixel_beat_type next_px;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         // the beat on the wires moves on this edge: predict its effect
         if (req_valid && !req_stall)
            segment_pixel({req_opcode, req_first_of_pass, req_gray, req_chroma});
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
               gap_left = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (pixel_stream.size() != 0) begin
               next_px = pixel_stream.pop_front();
               req_opcode        <= next_px.opcode;
               req_first_of_pass <= next_px.first;
               req_gray          <= next_px.gray;
               req_chroma        <= next_px.chroma;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest prediction and
   // hold off the result channel in random bursts.
   always @(posedge clock) begin : watch_rsp
      rsp_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (class_forecast.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $display("%0t: result beat with none expected, actual class %0d mean %0d",
                           $time, rsp_pixel_class, rsp_mean_level);
            end else begin
               want = class_forecast.pop_front();
               if (rsp_pixel_class !== want.pixel_class)
                  flag_mismatch("pixel_class", want.pixel_class, rsp_pixel_class);
               if (rsp_mean_level !== want.mean_level)
                  flag_mismatch("mean_level", want.mean_level, rsp_mean_level);
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_pixel(input logic op, input logic first, input int gray,
                              input int chroma);
      pixel_beat_type px;
      px.opcode = op;
      px.first  = first;
      px.gray   = gray[PIX_W-1:0];
      px.chroma = chroma[PIX_W-1:0];
      pixel_stream.push_back(px);
   endtask

   // Queue a run of measure pixels with gray drawn from [lo, hi].
   task automatic queue_measure(input int count, input logic first, input int lo, input int hi);
      for (int k = 0; k < count; k++)
         queue_pixel(OP_MEASURE, (k == 0) ? first : 1'b0, $urandom_range(lo, hi),
                     $urandom_range(0, 255));
   endtask

   // Queue classify pixels; half the grays sit low, near the usual means.
   task automatic queue_classify(input int count, input logic first);
      for (int k = 0; k < count; k++)
         queue_pixel(OP_CLASSIFY, (k == 0) ? first : ($urandom_range(0, 15) == 0),
                     $urandom_range(0, 1) ? $urandom_range(0, 48) : $urandom_range(0, 255),
                     $urandom_range(0, 255));
   endtask

   // Wait until every beat is sent and every result is in, then let the
   // pipeline empty out behind any trailing measure beats. Sample on the
   // falling edge so the driver's updates of this cycle have settled.
   task automatic drain();
      while (pixel_stream.size() != 0 || req_valid || class_forecast.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_W-1:0];
      @(posedge clock);
      // the write lands on this edge
      csr_write <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = value[CFG_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[CFG_W-1:0];
         CSR_UV_LIMIT:     cfg_uv     = value[PIX_W-1:0];
         default: ;
      endcase
   endtask

   // Reprogram the frame only when the segmenter is idle.
   task automatic set_frame(input int width, input int height, input int uv);
      drain();
      write_reg(CSR_FRAME_WIDTH, width);
      write_reg(CSR_FRAME_HEIGHT, height);
      write_reg(CSR_UV_LIMIT, uv);
   endtask

   function automatic int pick_dim();
      case ($urandom_range(0, 7))
         0:       return 50;
         1:       return 2048;
         2:       return $urandom_range(0, 1);
         3:       return $urandom_range(2, 49);
         4:       return $urandom_range(50, 2048);
         5:       return $urandom_range(2049, 4095);
         default: return $urandom_range(50, 64);
      endcase
   endfunction

   function automatic int pick_uv();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         2:       return 8;
         default: return 20;
      endcase
   endfunction

   initial begin : stimulus
      int count, lo, hi;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Classify before any measuring: the mean is still the reset zero.
      queue_pixel(OP_CLASSIFY, 1'b0, 0, 0);

      // 50x50 frame: the window covers every pixel.
      set_frame(50, 50, 255);
      // 3750 sits half way between 1 and 2: round up to the even 2
      for (int k = 0; k < 14; k++)
         queue_pixel(OP_MEASURE, k == 0, 255, 0);
      queue_pixel(OP_MEASURE, 1'b0, 180, 0);
      queue_pixel(OP_CLASSIFY, 1'b0, 1, 0);
      queue_pixel(OP_CLASSIFY, 1'b0, 2, 254);
      // 1250 sits half way between 0 and 1: round down to the even 0
      for (int k = 0; k < 4; k++)
         queue_pixel(OP_MEASURE, k == 0, 255, 255);
      queue_pixel(OP_MEASURE, 1'b0, 230, 0);
      queue_pixel(OP_CLASSIFY, 1'b1, 0, 0);
      // continue the pass without a start: 1251 gives 1, latched after measuring
      queue_pixel(OP_MEASURE, 1'b0, 1, 0);
      queue_pixel(OP_CLASSIFY, 1'b1, 0, 254);
      queue_pixel(OP_CLASSIFY, 1'b0, 0, 255);
      // a zero chroma limit lets nothing count as dark
      set_frame(50, 50, 0);
      queue_pixel(OP_CLASSIFY, 1'b0, 0, 0);

      // Bright start of a 50x50 frame: a partly filled window raises the mean.
      set_frame(50, 50, $urandom_range(100, 255));
      idle_odds = 8;
      queue_measure(500, 1'b1, 200, 255);
      queue_classify(40, 1'b0);

      // Top rows of a 52x51 frame: the window leaves out the outer columns.
      set_frame(52, 51, pick_uv());
      idle_odds = 3;
      queue_measure(52 * 4, 1'b1, 0, 255);
      queue_classify(30, 1'($urandom_range(0, 1)));

      // Zero width wraps the column after every pixel.
      set_frame(0, 100, 200);
      idle_odds = 0;
      queue_measure(200, 1'b1, 0, 255);
      queue_classify(10, 1'b0);

      // Random frames: mostly a measure pass then a classify run, some noise.
      while (random_items < RAND_ITEMS) begin
         if ($urandom_range(0, 2) == 0)
            set_frame(pick_dim(), pick_dim(), pick_uv());
         idle_odds = (random_items >= CALM_ITEMS) ? 0 : pick_idle();
         case ($urandom_range(0, 9))
            7: begin
               // noise: every field at random
               count = $urandom_range(1, 30);
               for (int k = 0; k < count; k++)
                  queue_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 255), $urandom_range(0, 255));
            end
            8: begin
               // resume the previous pass without a start
               count = $urandom_range(1, 100);
               queue_measure(count, 1'b0, 0, 255);
               queue_classify($urandom_range(1, 10), 1'b0);
               count += 10;
            end
            9: begin
               count = $urandom_range(1, 20);
               queue_classify(count, 1'($urandom_range(0, 1)));
            end
            default: begin
               lo    = $urandom_range(0, 255);
               hi    = $urandom_range(lo, 255);
               count = $urandom_range(1, 400);
               queue_measure(count, 1'b1, lo, hi);
               queue_classify($urandom_range(1, 24), 1'($urandom_range(0, 1)));
               count += 24;
            end
         endcase
         random_items += count;
      end

      idle_odds = 0;
      drain();
      if (error_count == 0) begin
         $display("** center_mean_dark_segmenter_top: PASSED **");
      end else begin
         $display("** center_mean_dark_segmenter_top: FAILED **");
      end
      $finish;
   end

   // Hard stop for a hung handshake or a result that never comes.
   initial begin : watchdog
      #(LIMIT_TIME);
      $display("** center_mean_dark_segmenter_top: FAILED **");
      $finish;
   end

endmodule
